[rtl/pru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement unit package
// Shared types and codes for the page replacement unit.
// ----------------------------------------------------------------------------
package pru_pkg;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LK_RD,
      ST_LK_CMP,
      ST_SEL,
      ST_EV_RD,
      ST_DONE
   } state_type;

   // Replacement policy codes.
   typedef enum logic [1:0] {
      POL_FIFO     = 2'd0,
      POL_LRU      = 2'd1,
      POL_CLOCK    = 2'd2,
      POL_ENHANCED = 2'd3
   } policy_type;

   // Configuration register indexes.
   localparam logic CSR_POLICY      = 1'b0;
   localparam logic CSR_FRAME_COUNT = 1'b1;

   localparam int FRAME_COUNT_W     = 4;
   localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 4'd8;

endpackage

[rtl/pru_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module pru_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/page_replacement_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement unit
// Looks up one page reference per command in a table of resident pages and
// replaces a frame on a fault by FIFO, LRU, Clock or Enhanced Clock.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Handshake
//  -------   -------------------------------------   ----------------------
//  request   req_page, req_is_write                  start high, busy low
//  response  rsp_hit, rsp_frame_index, rsp_evicted_* rsp_valid, one cycle
//  config    csr_index, csr_wdata                    csr_we, no wait
//
// A word's lookup takes one RAM read and one compare per frame in use; a hit
// ends the lookup at the matching frame and goes straight to the table
// update. On a fault the hand sweep runs for Clock and Enhanced Clock and is
// skipped for FIFO and LRU, then the victim's page is read. The done state
// writes the table and registers the response, which is shown in the cycle
// after that. The single read port of the page and timestamp RAMs sets the
// lookup length.
// Reset and every configuration write clear the table: valid,
// reference and modified bits live in flip-flops, so no clearing pass runs.
// The receiver cannot stall; a response is shown for one cycle while the unit
// is already idle and able to take the next word.
//
module page_replacement_unit #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_page,
   input  logic        req_is_write,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [2:0]  rsp_frame_index,
   output logic        rsp_evicted_valid,
   output logic [15:0] rsp_evicted_page,
   output logic [31:0] rsp_fault_count,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);

   // Advance a frame pointer, wrapping at the number of frames in use.
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] n);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(i) + (CNT_W+1)'(1);
      return (s >= {1'b0, n}) ? '0 : IDX_W'(s);
   endfunction

   pru_pkg::state_type state_ff, state_in;
   pru_pkg::policy_type policy_ff;
   logic [pru_pkg::FRAME_COUNT_W-1:0] frame_count_ff;

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 wr_ff, wr_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     victim_ff, victim_in;
   logic                 empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]     empty_ff, empty_in;
   logic [IDX_W-1:0]     best_ff, best_in;
   logic [31:0]          best_time_ff, best_time_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 phase_ff, phase_in;
   logic                 round_ff, round_in;
   logic [IDX_W-1:0]     hand_ff, hand_in;
   logic [31:0]          ref_time_ff, ref_time_in;
   logic [31:0]          faults_ff, faults_in;
   logic [FRAMES-1:0]    valid_ff, valid_in;
   logic [FRAMES-1:0]    refb_ff, refb_in;
   logic [FRAMES-1:0]    modb_ff, modb_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic [2:0]  rsp_frame_ff, rsp_frame_in;
   logic        rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [15:0] rsp_ev_page_ff, rsp_ev_page_in;
   logic [31:0] rsp_faults_ff, rsp_faults_in;

   // Memory ports.
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr, ram_raddr;
   logic [PAGE_BITS-1:0] page_rdata;
   logic [31:0]          time_rdata;

   logic [CNT_W-1:0] n_c;
   logic             accept_c;
   logic             match_c;
   logic             scan_last_c;
   logic             cnt_last_c;
   logic             sel_done_c;
   logic [IDX_W-1:0] sel_victim_c;
   logic             cond00_c, cond01_c;

   // Frames in use: zero counts as one, anything above FRAMES as FRAMES.
   always_comb begin
      if (frame_count_ff == '0) begin
         n_c = CNT_W'(1);
      end else if (32'(frame_count_ff) > FRAMES) begin
         n_c = CNT_W'(FRAMES);
      end else begin
         n_c = CNT_W'(frame_count_ff);
      end
   end

   assign accept_c    = start && (state_ff == pru_pkg::ST_IDLE);
   assign busy        = (state_ff != pru_pkg::ST_IDLE);
   assign match_c     = valid_ff[scan_ff] && (page_rdata == page_ff);
   assign scan_last_c = ((CNT_W+1)'(scan_ff) + (CNT_W+1)'(1)) == {1'b0, n_c};
   assign cnt_last_c  = ((CNT_W+1)'(cnt_ff) + (CNT_W+1)'(1)) == {1'b0, n_c};
   assign cond00_c    = !refb_ff[ptr_ff] && !modb_ff[ptr_ff];
   assign cond01_c    = !refb_ff[ptr_ff] && modb_ff[ptr_ff];

   // Hand sweep decision for Clock and Enhanced Clock. After two full rounds
   // without a victim, Enhanced Clock falls back to the frame at the hand.
   always_comb begin
      sel_done_c   = 1'b0;
      sel_victim_c = ptr_ff;
      if (policy_ff == pru_pkg::POL_CLOCK) begin
         sel_done_c = !refb_ff[ptr_ff];
      end else if (!phase_ff) begin
         sel_done_c = cond00_c;
      end else if (cond01_c) begin
         sel_done_c = 1'b1;
      end else if (cnt_last_c && round_ff) begin
         sel_done_c   = 1'b1;
         sel_victim_c = hand_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pru_pkg::ST_IDLE: begin
            if (start) begin
               state_in = pru_pkg::ST_LK_RD;
            end
         end
         pru_pkg::ST_LK_RD: begin
            state_in = pru_pkg::ST_LK_CMP;
         end
         pru_pkg::ST_LK_CMP: begin
            if (match_c) begin
               state_in = pru_pkg::ST_DONE;
            end else if (scan_last_c) begin
               if (policy_ff == pru_pkg::POL_FIFO || policy_ff == pru_pkg::POL_LRU) begin
                  state_in = pru_pkg::ST_EV_RD;
               end else begin
                  state_in = pru_pkg::ST_SEL;
               end
            end else begin
               state_in = pru_pkg::ST_LK_RD;
            end
         end
         pru_pkg::ST_SEL: begin
            if (sel_done_c) begin
               state_in = pru_pkg::ST_EV_RD;
            end
         end
         pru_pkg::ST_EV_RD: begin
            state_in = pru_pkg::ST_DONE;
         end
         pru_pkg::ST_DONE: begin
            state_in = pru_pkg::ST_IDLE;
         end
         default: begin
            state_in = pru_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      page_in         = page_ff;
      wr_in           = wr_ff;
      scan_in         = scan_ff;
      found_in        = found_ff;
      victim_in       = victim_ff;
      empty_found_in  = empty_found_ff;
      empty_in        = empty_ff;
      best_in         = best_ff;
      best_time_in    = best_time_ff;
      ptr_in          = ptr_ff;
      cnt_in          = cnt_ff;
      phase_in        = phase_ff;
      round_in        = round_ff;
      hand_in         = hand_ff;
      ref_time_in     = ref_time_ff;
      faults_in       = faults_ff;
      valid_in        = valid_ff;
      refb_in         = refb_ff;
      modb_in         = modb_ff;
      rsp_valid_in    = 1'b0;
      rsp_hit_in      = rsp_hit_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_faults_in   = rsp_faults_ff;
      ram_we          = 1'b0;
      ram_waddr       = victim_ff;
      ram_raddr       = scan_ff;

      unique case (state_ff)
         pru_pkg::ST_IDLE: begin
            if (accept_c) begin
               page_in        = PAGE_BITS'(req_page);
               wr_in          = req_is_write;
               scan_in        = '0;
               found_in       = 1'b0;
               empty_found_in = 1'b0;
               if ((CNT_W+1)'(hand_ff) >= {1'b0, n_c}) begin
                  hand_in = '0;
               end
            end
         end
         pru_pkg::ST_LK_RD: begin
            ram_raddr = scan_ff;
         end
         pru_pkg::ST_LK_CMP: begin
            // The same pass gathers the LRU candidates: the first empty frame
            // and the oldest stamp, lowest index winning ties.
            if (!valid_ff[scan_ff] && !empty_found_ff) begin
               empty_found_in = 1'b1;
               empty_in       = scan_ff;
            end
            if (scan_ff == '0 || time_rdata < best_time_ff) begin
               best_in      = scan_ff;
               best_time_in = time_rdata;
            end
            if (match_c) begin
               found_in  = 1'b1;
               victim_in = scan_ff;
            end else if (scan_last_c) begin
               ptr_in   = hand_ff;
               cnt_in   = '0;
               phase_in = 1'b0;
               round_in = 1'b0;
               if (policy_ff == pru_pkg::POL_FIFO) begin
                  victim_in = hand_ff;
                  hand_in   = next_slot(hand_ff, n_c);
               end else if (policy_ff == pru_pkg::POL_LRU) begin
                  if (!valid_ff[scan_ff] && !empty_found_ff) begin
                     victim_in = scan_ff;
                  end else if (empty_found_ff) begin
                     victim_in = empty_ff;
                  end else if (scan_ff != '0 && time_rdata < best_time_ff) begin
                     victim_in = scan_ff;
                  end else begin
                     victim_in = best_ff;
                  end
               end
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         pru_pkg::ST_SEL: begin
            if (sel_done_c) begin
               victim_in = sel_victim_c;
               hand_in   = next_slot(sel_victim_c, n_c);
            end else if (policy_ff == pru_pkg::POL_CLOCK) begin
               refb_in[ptr_ff] = 1'b0;
               ptr_in          = next_slot(ptr_ff, n_c);
            end else begin
               // Enhanced Clock: the second scan of a round clears the
               // reference bit of each frame it passes.
               if (phase_ff) begin
                  refb_in[ptr_ff] = 1'b0;
               end
               if (cnt_last_c) begin
                  cnt_in = '0;
                  ptr_in = hand_ff;
                  if (phase_ff) begin
                     phase_in = 1'b0;
                     round_in = 1'b1;
                  end else begin
                     phase_in = 1'b1;
                  end
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  ptr_in = next_slot(ptr_ff, n_c);
               end
            end
         end
         pru_pkg::ST_EV_RD: begin
            ram_raddr = victim_ff;
         end
         pru_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_frame_in = 3'(victim_ff);
            if (ref_time_ff != '1) begin
               ref_time_in = ref_time_ff + 32'd1;
            end
            if (found_ff) begin
               rsp_hit_in      = 1'b1;
               rsp_ev_valid_in = 1'b0;
               rsp_ev_page_in  = '0;
               rsp_faults_in   = faults_ff;
               if (policy_ff == pru_pkg::POL_LRU) begin
                  ram_we = 1'b1;
               end
               if (policy_ff == pru_pkg::POL_CLOCK || policy_ff == pru_pkg::POL_ENHANCED) begin
                  refb_in[victim_ff] = 1'b1;
               end
               if (policy_ff == pru_pkg::POL_ENHANCED && wr_ff) begin
                  modb_in[victim_ff] = 1'b1;
               end
            end else begin
               rsp_hit_in      = 1'b0;
               rsp_ev_valid_in = valid_ff[victim_ff];
               rsp_ev_page_in  = valid_ff[victim_ff] ? 16'(page_rdata) : '0;
               if (faults_ff != '1) begin
                  faults_in     = faults_ff + 32'd1;
                  rsp_faults_in = faults_ff + 32'd1;
               end else begin
                  rsp_faults_in = faults_ff;
               end
               ram_we              = 1'b1;
               valid_in[victim_ff] = 1'b1;
               if (policy_ff == pru_pkg::POL_CLOCK || policy_ff == pru_pkg::POL_ENHANCED) begin
                  refb_in[victim_ff] = 1'b1;
               end
               if (policy_ff == pru_pkg::POL_ENHANCED) begin
                  modb_in[victim_ff] = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control state. A configuration write clears the table; the user must write
   // only while the unit is idle, and the unit itself does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pru_pkg::ST_IDLE;
         policy_ff      <= pru_pkg::POL_FIFO;
         frame_count_ff <= pru_pkg::FRAME_COUNT_RESET;
         hand_ff        <= '0;
         ref_time_ff    <= '0;
         faults_ff      <= '0;
         valid_ff       <= '0;
         refb_ff        <= '0;
         modb_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            pru_pkg::CSR_POLICY: begin
               policy_ff <= pru_pkg::policy_type'(csr_wdata[1:0]);
            end
            pru_pkg::CSR_FRAME_COUNT: begin
               frame_count_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
         state_ff     <= state_in;
         hand_ff      <= '0;
         ref_time_ff  <= '0;
         faults_ff    <= '0;
         valid_ff     <= '0;
         refb_ff      <= '0;
         modb_ff      <= '0;
         rsp_valid_ff <= rsp_valid_in;
      end else begin
         state_ff     <= state_in;
         hand_ff      <= hand_in;
         ref_time_ff  <= ref_time_in;
         faults_ff    <= faults_in;
         valid_ff     <= valid_in;
         refb_ff      <= refb_in;
         modb_ff      <= modb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      page_ff         <= page_in;
      wr_ff           <= wr_in;
      scan_ff         <= scan_in;
      found_ff        <= found_in;
      victim_ff       <= victim_in;
      empty_found_ff  <= empty_found_in;
      empty_ff        <= empty_in;
      best_ff         <= best_in;
      best_time_ff    <= best_time_in;
      ptr_ff          <= ptr_in;
      cnt_ff          <= cnt_in;
      phase_ff        <= phase_in;
      round_ff        <= round_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_faults_ff   <= rsp_faults_in;
   end

   // Resident page numbers and LRU timestamps, one entry per frame.
   pru_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (FRAMES)
   ) u_page_ram (
      .clock (clock),
      .we    (ram_we && !found_ff),
      .waddr (ram_waddr),
      .wdata (page_ff),
      .raddr (ram_raddr),
      .rdata (page_rdata)
   );

   pru_ram #(
      .WIDTH (32),
      .DEPTH (FRAMES)
   ) u_time_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ref_time_ff),
      .raddr (ram_raddr),
      .rdata (time_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_count   = rsp_faults_ff;

endmodule

[rtl/pru_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement unit checker
// Port-level properties of the page replacement unit.
// ----------------------------------------------------------------------------
module pru_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_hit,
   input logic        rsp_evicted_valid,
   input logic [31:0] rsp_fault_count
);

   // An accepted word keeps the unit busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after accepting a word");

   // A response appears only once the unit is idle again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // A hit never evicts a page.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted_valid)
      else $error("eviction reported on a hit");

   // A fault is always counted.
   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_fault_count != 32'd0))
      else $error("fault without a fault count");

endmodule

bind page_replacement_unit pru_checker u_pru_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_fault_count   (rsp_fault_count)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement unit testbench
// Sends page references through the command port under all four replacement
// policies and several frame counts. A table model inside the bench predicts
// every response word, and a checker compares each field as it appears.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NFR   = 8;
   localparam int WDOG  = 5000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_page;
   logic        req_is_write;
   logic        rsp_valid;
   logic        rsp_hit;
   logic [2:0]  rsp_frame_index;
   logic        rsp_evicted_valid;
   logic [15:0] rsp_evicted_page;
   logic [31:0] rsp_fault_count;
   logic        csr_we;
   logic        csr_index;
   logic [3:0]  csr_wdata;

   page_replacement_unit #(.FRAMES(NFR), .PAGE_BITS(16)) uut (.*);

   // One predicted response word.
   typedef struct packed {
      logic        hit;
      logic [2:0]  frame;
      logic        ev_valid;
      logic [15:0] ev_page;
      logic [31:0] faults;
   } lookup_word_type;

   lookup_word_type pending_lookups[$];

   // Mirror of the unit's table and registers.
   pru_pkg::policy_type m_policy;
   logic [3:0]  m_count;
   logic [15:0] m_page  [NFR];
   logic        m_valid [NFR];
   logic        m_ref   [NFR];
   logic        m_mod   [NFR];
   logic [31:0] m_stamp [NFR];
   int unsigned m_hand;
   logic [31:0] m_time;
   logic [31:0] m_faults;

   int unsigned errors;
   int unsigned words_sent;
   int unsigned words_seen;
   int unsigned hits_seen;
   int unsigned evicts_seen;
   int unsigned idle_cycles;

   // Working set of pages for one phase, so that hits and evictions both occur.
   logic [15:0] page_pool[12];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_mirror();
      for (int i = 0; i < NFR; i++) begin
         m_page[i]  = '0;
         m_valid[i] = 1'b0;
         m_ref[i]   = 1'b0;
         m_mod[i]   = 1'b0;
         m_stamp[i] = '0;
      end
      m_hand   = 0;
      m_time   = '0;
      m_faults = '0;
   endfunction

   function automatic int unsigned frames_active();
      if (m_count < 4'd1) return 1;
      if (m_count > NFR) return NFR;
      return m_count;
   endfunction

   function automatic int unsigned wrap_next(int unsigned i, int unsigned n);
      return (i + 1 >= n) ? 0 : i + 1;
   endfunction

   // Enhanced Clock victim search: a clean unreferenced frame first, then a
   // dirty unreferenced one while clearing reference bits, at most two rounds.
   function automatic int unsigned enhanced_victim(int unsigned n);
      int unsigned idx;
      for (int r = 0; r < 2; r++) begin
         for (int unsigned i = 0; i < n; i++) begin
            idx = (m_hand + i) % n;
            if (!m_ref[idx] && !m_mod[idx]) begin
               m_hand = wrap_next(idx, n);
               return idx;
            end
         end
         for (int unsigned i = 0; i < n; i++) begin
            idx = (m_hand + i) % n;
            if (!m_ref[idx] && m_mod[idx]) begin
               m_hand = wrap_next(idx, n);
               return idx;
            end
            m_ref[idx] = 1'b0;
         end
      end
      idx = m_hand;
      m_hand = wrap_next(idx, n);
      return idx;
   endfunction

   // Computes the response to one reference and updates the mirror.
   function automatic lookup_word_type predict_lookup(logic [15:0] pg, logic wr);
      lookup_word_type w;
      int unsigned n;
      int unsigned v;
      int unsigned h;
      logic found;
      n = frames_active();
      v = 0;
      found = 1'b0;
      w = '0;
      if (m_hand >= n) m_hand = 0;
      for (int unsigned i = 0; i < n; i++) begin
         if (!found && m_valid[i] && m_page[i] == pg) begin
            found = 1'b1;
            v = i;
         end
      end
      if (found) begin
         if (m_policy == pru_pkg::POL_LRU) begin
            m_stamp[v] = m_time;
         end else if (m_policy == pru_pkg::POL_CLOCK || m_policy == pru_pkg::POL_ENHANCED) begin
            m_ref[v] = 1'b1;
            if (m_policy == pru_pkg::POL_ENHANCED && wr) m_mod[v] = 1'b1;
         end
      end else begin
         if (m_faults != 32'hFFFF_FFFF) m_faults++;
         case (m_policy)
            pru_pkg::POL_FIFO: begin
               v = m_hand;
               m_hand = wrap_next(m_hand, n);
            end
            pru_pkg::POL_LRU: begin
               v = n;
               for (int unsigned i = 0; i < n; i++)
                  if (v == n && !m_valid[i]) v = i;
               if (v == n) begin
                  v = 0;
                  for (int unsigned i = 1; i < n; i++)
                     if (m_stamp[i] < m_stamp[v]) v = i;
               end
            end
            pru_pkg::POL_CLOCK: begin
               h = m_hand;
               for (int unsigned g = 0; g < 2 * n + 1; g++) begin
                  if (!m_ref[h]) break;
                  m_ref[h] = 1'b0;
                  h = wrap_next(h, n);
               end
               m_hand = wrap_next(h, n);
               v = h;
            end
            default: v = enhanced_victim(n);
         endcase
         if (m_valid[v]) begin
            w.ev_valid = 1'b1;
            w.ev_page  = m_page[v];
         end
         m_page[v]  = pg;
         m_valid[v] = 1'b1;
         m_stamp[v] = m_time;
         if (m_policy == pru_pkg::POL_CLOCK || m_policy == pru_pkg::POL_ENHANCED) m_ref[v] = 1'b1;
         if (m_policy == pru_pkg::POL_ENHANCED) m_mod[v] = 1'b0;
      end
      if (m_time != 32'hFFFF_FFFF) m_time++;
      w.hit    = found;
      w.frame  = v[2:0];
      w.faults = m_faults;
      return w;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(1, 3);
   endfunction

   // Sends one word. Called at a rising edge; returns at a rising edge.
   task automatic send_word(logic [15:0] pg, logic wr, int unsigned gap);
      start        <= 1'b1;
      req_page     <= pg;
      req_is_write <= wr;
      do @(posedge clock); while (busy);
      pending_lookups.push_back(predict_lookup(pg, wr));
      words_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every predicted word has come back and the unit is quiet.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register writes happen only while the unit is idle. Every write clears
   // the table, so the mirror is cleared as well.
   task automatic write_reg(logic idx, logic [3:0] val);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == pru_pkg::CSR_POLICY) m_policy = pru_pkg::policy_type'(val[1:0]);
      else m_count = val;
      clear_mirror();
   endtask

   task automatic fill_pool();
      for (int i = 0; i < 12; i++) page_pool[i] = 16'($urandom);
   endtask

   // Random references drawn mostly from a small working set; the number of pool
   // pages in use relative to the frame count decides how often faults happen.
   task automatic random_burst(int unsigned count, int unsigned span);
      logic [15:0] pg;
      for (int unsigned k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) == 0) pg = 16'($urandom);
         else pg = page_pool[$urandom_range(0, span - 1)];
         send_word(pg, 1'($urandom), pick_gap());
      end
   endtask

   // Extremes of the page field, a hit with a write, and a full FIFO cycle
   // with evictions, then both frame count extremes.
   task automatic test_directed();
      send_word(16'h0000, 1'b0, 0);
      send_word(16'hFFFF, 1'b1, 1);
      send_word(16'h0000, 1'b1, 0);
      for (int i = 1; i <= 8; i++) send_word(16'(i * 16'h1111), 1'b0, 0);
      send_word(16'hFFFF, 1'b0, 2);
      // A frame count of zero acts as one frame.
      write_reg(pru_pkg::CSR_FRAME_COUNT, 4'd0);
      send_word(16'hA5A5, 1'b0, 0);
      send_word(16'h5A5A, 1'b1, 0);
      send_word(16'h5A5A, 1'b0, 0);
      // Anything above the frame limit acts as the limit.
      write_reg(pru_pkg::CSR_FRAME_COUNT, 4'd15);
      for (int i = 0; i < 10; i++) send_word(16'(i), 1'b0, 0);
   endtask

   // Enhanced Clock where every frame is referenced and dirty, so the search
   // needs its second round.
   task automatic test_enhanced_rounds();
      write_reg(pru_pkg::CSR_POLICY, 4'hF);
      write_reg(pru_pkg::CSR_FRAME_COUNT, 4'd3);
      for (int i = 0; i < 3; i++) send_word(16'(16'h100 + i), 1'b0, 0);
      for (int i = 0; i < 3; i++) send_word(16'(16'h100 + i), 1'b1, 0);
      send_word(16'h0200, 1'b0, 0);
      send_word(16'h0201, 1'b1, 1);
   endtask

   task automatic test_policy(pru_pkg::policy_type pol, int unsigned count);
      logic [3:0] fc;
      write_reg(pru_pkg::CSR_POLICY, {2'($urandom), pol});
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: fc = 4'd1;
            1: fc = 4'd8;
            default: fc = 4'($urandom_range(2, 7));
         endcase
         write_reg(pru_pkg::CSR_FRAME_COUNT, fc);
         fill_pool();
         random_burst(count / 4, $urandom_range(2, 12));
      end
   endtask

   // The sender holds off until the unit has answered everything, then
   // resumes on the same table.
   task automatic test_drain_pause();
      write_reg(pru_pkg::CSR_POLICY, {2'b00, pru_pkg::POL_LRU});
      write_reg(pru_pkg::CSR_FRAME_COUNT, 4'd4);
      fill_pool();
      random_burst(20, 6);
      drain();
      random_burst(20, 6);
   endtask

   // Checks each response word against the oldest prediction.
   always @(posedge clock) begin
      lookup_word_type e;
      if (!reset && rsp_valid) begin
         words_seen++;
         if (pending_lookups.size() == 0) begin
            $error("response word with nothing predicted");
            errors++;
         end else begin
            e = pending_lookups.pop_front();
            if (rsp_hit) hits_seen++;
            if (rsp_evicted_valid) evicts_seen++;
            if (rsp_hit !== e.hit) begin
               $error("hit: expected %0d, got %0d", e.hit, rsp_hit);
               errors++;
            end
            if (rsp_frame_index !== e.frame) begin
               $error("frame_index: expected %0d, got %0d", e.frame, rsp_frame_index);
               errors++;
            end
            if (rsp_evicted_valid !== e.ev_valid) begin
               $error("evicted_valid: expected %0d, got %0d",
                      e.ev_valid, rsp_evicted_valid);
               errors++;
            end
            if (e.ev_valid && rsp_evicted_page !== e.ev_page) begin
               $error("evicted_page: expected %h, got %h", e.ev_page, rsp_evicted_page);
               errors++;
            end
            if (rsp_fault_count !== e.faults) begin
               $error("fault_count: expected %0d, got %0d", e.faults, rsp_fault_count);
               errors++;
            end
         end
      end
   end

   // The watchdog restarts whenever a word moves in either direction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG) begin
         $display("watchdog expired with %0d words outstanding", pending_lookups.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset        <= 1'b1;
      start        <= 1'b0;
      req_page     <= '0;
      req_is_write <= 1'b0;
      csr_we       <= 1'b0;
      csr_index    <= 1'b0;
      csr_wdata    <= '0;
      errors       = 0;
      words_sent   = 0;
      words_seen   = 0;
      hits_seen    = 0;
      evicts_seen  = 0;
      m_policy     = pru_pkg::POL_FIFO;
      m_count      = pru_pkg::FRAME_COUNT_RESET;
      clear_mirror();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_enhanced_rounds();
      test_policy(pru_pkg::POL_FIFO, 200);
      test_policy(pru_pkg::POL_LRU, 200);
      test_policy(pru_pkg::POL_CLOCK, 200);
      test_policy(pru_pkg::POL_ENHANCED, 200);
      test_drain_pause();

      drain();
      repeat (60) @(posedge clock);
      $display("Ran %0d references over FIFO, LRU, Clock and Enhanced Clock;", words_sent);
      $display("%0d responses checked, %0d hits, %0d evictions.",
               words_seen, hits_seen, evicts_seen);
      if (errors == 0 && pending_lookups.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/pru_pkg.sv
rtl/pru_ram.sv
rtl/page_replacement_unit.sv
rtl/pru_checker.sv
verif/tb_top.sv
